@@ src/bcx_pkg.sv @@
// Shared types, command codes and helpers for the byte CPU execute unit.
// No dependencies; the stack, ALU, top level and testbench import this package.
package bcx_pkg;

  localparam int unsigned StackDepth = 256;
  localparam int unsigned SpW        = $clog2(StackDepth);
  localparam int unsigned PaddrW     = 3;

  localparam logic [7:0]  SpReset  = 8'hFF;
  localparam logic [7:0]  FlagN    = 8'h80;
  localparam logic [7:0]  FlagV    = 8'h40;
  localparam logic [7:0]  FlagB    = 8'h10;
  localparam logic [7:0]  FlagD    = 8'h08;
  localparam logic [7:0]  FlagI    = 8'h04;
  localparam logic [7:0]  FlagZ    = 8'h02;
  localparam logic [7:0]  FlagC    = 8'h01;
  localparam logic [15:0] BreakVectorReset = 16'h0000;

  localparam logic [0:0] RegBreakVector = 1'b0;

  localparam logic [1:0] ExtraNone  = 2'd0;
  localparam logic [1:0] ExtraTaken = 2'd1;
  localparam logic [1:0] ExtraPage  = 2'd2;

  typedef enum logic [5:0] {
    CMD_ADC = 6'd0,  CMD_AND = 6'd1,  CMD_ASL = 6'd2,  CMD_BCC = 6'd3,
    CMD_BCS = 6'd4,  CMD_BEQ = 6'd5,  CMD_BIT = 6'd6,  CMD_BMI = 6'd7,
    CMD_BNE = 6'd8,  CMD_BPL = 6'd9,  CMD_BRK = 6'd10, CMD_BVC = 6'd11,
    CMD_BVS = 6'd12, CMD_CLC = 6'd13, CMD_CLD = 6'd14, CMD_CLI = 6'd15,
    CMD_CLV = 6'd16, CMD_CMP = 6'd17, CMD_CPX = 6'd18, CMD_CPY = 6'd19,
    CMD_DEC = 6'd20, CMD_DEX = 6'd21, CMD_DEY = 6'd22, CMD_EOR = 6'd23,
    CMD_INC = 6'd24, CMD_INX = 6'd25, CMD_INY = 6'd26, CMD_JMP = 6'd27,
    CMD_JSR = 6'd28, CMD_LDA = 6'd29, CMD_LDX = 6'd30, CMD_LDY = 6'd31,
    CMD_LSR = 6'd32, CMD_NOP = 6'd33, CMD_ORA = 6'd34, CMD_PHA = 6'd35,
    CMD_PHP = 6'd36, CMD_PLA = 6'd37, CMD_PLP = 6'd38, CMD_ROL = 6'd39,
    CMD_ROR = 6'd40, CMD_RTI = 6'd41, CMD_RTS = 6'd42, CMD_SBC = 6'd43,
    CMD_SEC = 6'd44, CMD_SED = 6'd45, CMD_SEI = 6'd46, CMD_STA = 6'd47,
    CMD_STX = 6'd48, CMD_STY = 6'd49, CMD_TAX = 6'd50, CMD_TAY = 6'd51,
    CMD_TSX = 6'd52, CMD_TXA = 6'd53, CMD_TXS = 6'd54, CMD_TYA = 6'd55
  } cmd_t;

  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  p;
    logic [15:0] pc;
  } regs_t;

  typedef struct packed {
    logic           we;
    logic [SpW-1:0] waddr;
    logic [7:0]     wdata;
    logic [SpW-1:0] raddr;
  } stk_req_t;

  // Number of stack bytes an instruction moves.
  function automatic logic [1:0] stack_len(input logic [5:0] cmd);
    case (cmd)
      CMD_BRK, CMD_RTI:                   stack_len = 2'd3;
      CMD_JSR, CMD_RTS:                   stack_len = 2'd2;
      CMD_PHA, CMD_PHP, CMD_PLA, CMD_PLP: stack_len = 2'd1;
      default:                            stack_len = 2'd0;
    endcase
  endfunction

  function automatic logic is_pop(input logic [5:0] cmd);
    case (cmd)
      CMD_PLA, CMD_PLP, CMD_RTI, CMD_RTS: is_pop = 1'b1;
      default:                            is_pop = 1'b0;
    endcase
  endfunction

endpackage

@@ src/bcx_if.sv @@
// Request and result channel interfaces for the byte CPU execute unit.
// Depends on no other file.
interface bcx_in_if;
  logic       valid;
  logic       ready;
  logic [5:0] cmd;
  logic [7:0] operand;
  logic [7:0] operand_high;
  modport source (output valid, cmd, operand, operand_high, input ready);
  modport sink   (input valid, cmd, operand, operand_high, output ready);
endinterface

interface bcx_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  mem_data;
  logic [7:0]  acc_out;
  logic [7:0]  x_out;
  logic [7:0]  y_out;
  logic [7:0]  sp_out;
  logic [7:0]  status_out;
  logic [15:0] pc_out;
  logic [1:0]  extra_cycles;
  modport source (output valid, mem_data, acc_out, x_out, y_out, sp_out, status_out,
                  pc_out, extra_cycles, input ready);
  modport sink   (input valid, mem_data, acc_out, x_out, y_out, sp_out, status_out,
                  pc_out, extra_cycles, output ready);
endinterface

@@ src/bcx_stack.sv @@
// 256-byte stack page: one write port, one registered read port.
// Depends on bcx_pkg; entries never written read as zero via valid bits.
module bcx_stack
  import bcx_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  stk_req_t   req,
  output logic [7:0] rdata
);

  logic [7:0]            mem [StackDepth];
  logic [StackDepth-1:0] vld;
  logic [7:0]            rd_q;
  logic                  rv_q;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    rd_q <= mem[req.raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      rv_q <= 1'b0;
    end else begin
      if (req.we) begin
        vld[req.waddr] <= 1'b1;
      end
      rv_q <= vld[req.raddr];
    end
  end

  assign rdata = rv_q ? rd_q : 8'h00;

endmodule

@@ src/bcx_alu.sv @@
// Combinational execute logic: next register file, memory byte, branch cycles.
// Depends on bcx_pkg.
module bcx_alu
  import bcx_pkg::*;
(
  input  regs_t           cur,
  input  logic [5:0]      cmd,
  input  logic [7:0]      operand,
  input  logic [7:0]      operand_high,
  input  logic [15:0]     break_vector,
  input  logic [2:0][7:0] pop_bytes,
  output regs_t           nxt,
  output logic [7:0]      mem_data,
  output logic [1:0]      extra_cycles
);

  logic [9:0]  sum;
  logic [10:0] dif;
  logic        cin;
  logic        bor;
  logic        take;
  logic [15:0] tgt;
  logic [7:0]  cmpd;
  logic [7:0]  cmpr;

  function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
    nz = (p & ~(FlagN | FlagZ)) | (v[7] ? FlagN : 8'h00) | ((v == 8'h00) ? FlagZ : 8'h00);
  endfunction

  function automatic logic [7:0] putf(input logic [7:0] p, input logic [7:0] b,
                                      input logic on);
    putf = on ? (p | b) : (p & ~b);
  endfunction

  always_comb begin
    nxt          = cur;
    mem_data     = 8'h00;
    extra_cycles = ExtraNone;
    cin          = cur.p[0];
    bor          = ~cur.p[0];
    sum          = {2'b00, cur.a} + {2'b00, operand} + {9'd0, cin};
    dif          = {3'b000, cur.a} - {3'b000, operand} - {10'd0, bor};
    tgt          = cur.pc + {{8{operand[7]}}, operand};
    take         = 1'b0;
    cmpr         = cur.a;
    cmpd         = 8'h00;

    case (cmd)
      CMD_ADC: begin
        nxt.p = putf(nxt.p, FlagZ, sum[7:0] == 8'h00);
        if (cur.p[3]) begin
          if ({1'b0, cur.a[3:0]} + {1'b0, operand[3:0]} + {4'd0, cin} > 5'd9) begin
            sum = sum + 10'd6;
          end
          nxt.p = putf(nxt.p, FlagN, sum[7]);
          nxt.p = putf(nxt.p, FlagV, ~(cur.a[7] ^ operand[7]) & (cur.a[7] ^ sum[7]));
          if (sum > 10'h099) begin
            sum = sum + 10'd96;
          end
          nxt.p = putf(nxt.p, FlagC, sum > 10'h099);
        end else begin
          nxt.p = putf(nxt.p, FlagN, sum[7]);
          nxt.p = putf(nxt.p, FlagV, ~(cur.a[7] ^ operand[7]) & (cur.a[7] ^ sum[7]));
          nxt.p = putf(nxt.p, FlagC, sum[8]);
        end
        nxt.a = sum[7:0];
      end
      CMD_SBC: begin
        nxt.p = putf(nxt.p, FlagN, dif[7]);
        nxt.p = putf(nxt.p, FlagZ, dif[7:0] == 8'h00);
        nxt.p = putf(nxt.p, FlagV, (cur.a[7] ^ dif[7]) & (cur.a[7] ^ operand[7]));
        if (cur.p[3]) begin
          if ({1'b0, cur.a[3:0]} < {1'b0, operand[3:0]} + {4'd0, bor}) begin
            dif = dif - 11'd6;
          end
          // negative differences count as huge unsigned values
          if (dif[10] || dif > 11'h099) begin
            dif = dif - 11'd96;
          end
        end
        nxt.p = putf(nxt.p, FlagC, dif[10:8] == 3'b000);
        nxt.a = dif[7:0];
      end
      CMD_AND: begin nxt.a = cur.a & operand; nxt.p = nz(cur.p, nxt.a); end
      CMD_ORA: begin nxt.a = cur.a | operand; nxt.p = nz(cur.p, nxt.a); end
      CMD_EOR: begin nxt.a = cur.a ^ operand; nxt.p = nz(cur.p, nxt.a); end
      CMD_ASL: begin
        mem_data = {operand[6:0], 1'b0};
        nxt.p    = nz(putf(cur.p, FlagC, operand[7]), mem_data);
      end
      CMD_LSR: begin
        mem_data = {1'b0, operand[7:1]};
        nxt.p    = nz(putf(cur.p, FlagC, operand[0]), mem_data);
      end
      CMD_ROL: begin
        mem_data = {operand[6:0], cin};
        nxt.p    = nz(putf(cur.p, FlagC, operand[7]), mem_data);
      end
      CMD_ROR: begin
        mem_data = {cin, operand[7:1]};
        nxt.p    = nz(putf(cur.p, FlagC, operand[0]), mem_data);
      end
      CMD_BCC: take = ~cur.p[0];
      CMD_BCS: take = cur.p[0];
      CMD_BEQ: take = cur.p[1];
      CMD_BNE: take = ~cur.p[1];
      CMD_BMI: take = cur.p[7];
      CMD_BPL: take = ~cur.p[7];
      CMD_BVC: take = ~cur.p[6];
      CMD_BVS: take = cur.p[6];
      CMD_BIT: begin
        nxt.p = putf(cur.p, FlagV, operand[6]);
        nxt.p = putf(nxt.p, FlagN, operand[7]);
        nxt.p = putf(nxt.p, FlagZ, (operand & cur.a) == 8'h00);
      end
      CMD_BRK: begin
        nxt.p  = cur.p | FlagI;
        nxt.pc = break_vector;
      end
      CMD_CLC: nxt.p = cur.p & ~FlagC;
      CMD_CLD: nxt.p = cur.p & ~FlagD;
      CMD_CLI: nxt.p = cur.p & ~FlagI;
      CMD_CLV: nxt.p = cur.p & ~FlagV;
      CMD_SEC: nxt.p = cur.p | FlagC;
      CMD_SED: nxt.p = cur.p | FlagD;
      CMD_SEI: nxt.p = cur.p | FlagI;
      CMD_CMP, CMD_CPX, CMD_CPY: begin
        if (cmd == CMD_CPX) begin
          cmpr = cur.x;
        end else if (cmd == CMD_CPY) begin
          cmpr = cur.y;
        end
        cmpd  = cmpr - operand;
        nxt.p = nz(putf(cur.p, FlagC, cmpr >= operand), cmpd);
      end
      CMD_DEC: begin mem_data = operand - 8'd1; nxt.p = nz(cur.p, mem_data); end
      CMD_INC: begin mem_data = operand + 8'd1; nxt.p = nz(cur.p, mem_data); end
      CMD_DEX: begin nxt.x = cur.x - 8'd1; nxt.p = nz(cur.p, nxt.x); end
      CMD_DEY: begin nxt.y = cur.y - 8'd1; nxt.p = nz(cur.p, nxt.y); end
      CMD_INX: begin nxt.x = cur.x + 8'd1; nxt.p = nz(cur.p, nxt.x); end
      CMD_INY: begin nxt.y = cur.y + 8'd1; nxt.p = nz(cur.p, nxt.y); end
      CMD_JMP, CMD_JSR: nxt.pc = {operand_high, operand};
      CMD_LDA: begin nxt.a = operand; nxt.p = nz(cur.p, nxt.a); end
      CMD_LDX: begin nxt.x = operand; nxt.p = nz(cur.p, nxt.x); end
      CMD_LDY: begin nxt.y = operand; nxt.p = nz(cur.p, nxt.y); end
      CMD_PLA: begin nxt.a = pop_bytes[0]; nxt.p = nz(cur.p, nxt.a); end
      CMD_PLP: nxt.p = pop_bytes[0];
      CMD_RTI: begin
        nxt.p  = pop_bytes[0];
        nxt.pc = {pop_bytes[2], pop_bytes[1]};
      end
      CMD_RTS: nxt.pc = {pop_bytes[1], pop_bytes[0]} + 16'd1;
      CMD_STA: mem_data = cur.a;
      CMD_STX: mem_data = cur.x;
      CMD_STY: mem_data = cur.y;
      CMD_TAX: begin nxt.x = cur.a;  nxt.p = nz(cur.p, nxt.x); end
      CMD_TAY: begin nxt.y = cur.a;  nxt.p = nz(cur.p, nxt.y); end
      CMD_TSX: begin nxt.x = cur.sp; nxt.p = nz(cur.p, nxt.x); end
      CMD_TXA: begin nxt.a = cur.x;  nxt.p = nz(cur.p, nxt.a); end
      CMD_TYA: begin nxt.a = cur.y;  nxt.p = nz(cur.p, nxt.a); end
      CMD_TXS: nxt.sp = cur.x;
      default: nxt = cur;
    endcase

    if (take) begin
      nxt.pc       = tgt;
      extra_cycles = (tgt[15:8] != cur.pc[15:8]) ? ExtraPage : ExtraTaken;
    end
  end

endmodule

@@ src/byte_cpu_execute_unit.sv @@
// Top level of the byte CPU execute unit: request register, stack sequencer,
// register file, result register and APB register. Depends on bcx_pkg, bcx_if,
// bcx_alu and bcx_stack.
//
//  channel   dir  handshake          payload
//  instr     in   valid/ready        cmd, operand, operand_high
//  result    out  valid/ready        mem_data, acc_out ... extra_cycles
//  apb       in   psel/penable       paddr, pwdata -> break_vector (byte addr 0)
//
// One request per cycle for all instructions that do not touch the stack, unless the
// result stalls. PHA/PHP, JSR and BRK push one byte per step (one stack write port);
// PLA/PLP, RTS and RTI first issue the registered stack read, then pop one byte per step.
// rst clears A, X, Y, P, PC, break_vector, sets SP to 0xFF; stack bytes read
// as zero until written. A stalled result holds; the request register still
// drains into it as soon as the result register frees up.
module byte_cpu_execute_unit
  import bcx_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  bcx_in_if.sink            instr,
  bcx_out_if.source         result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // request register
  logic       ivalid;
  logic [5:0] cmd_q;
  logic [7:0] op_q;
  logic [7:0] hi_q;
  logic [1:0] step;

  // architectural state
  regs_t      regs;
  regs_t      regs_next;
  logic [15:0] break_vector;

  regs_t           alu_regs;
  logic [7:0]      alu_mem;
  logic [1:0]      alu_extra;
  logic [2:0][7:0] pop_bytes;
  logic [1:0][7:0] pop_hold;
  logic [7:0]      rdata;
  stk_req_t        stk_req;

  logic [1:0] len;
  logic       popping;
  logic       last;
  logic       done;
  logic       advance;
  logic       accept;
  logic       push_step;
  logic       pop_step;
  logic [15:0] ret_pc;
  logic [7:0]  push_byte;

  // result register
  logic        ovalid;

  assign pready = 1'b1;
  assign prdata = (paddr[PaddrW-1] == RegBreakVector) ? {16'h0000, break_vector} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      break_vector <= BreakVectorReset;
    end else if (psel && penable && pwrite && pready && paddr[PaddrW-1] == RegBreakVector) begin
      break_vector <= pwdata[15:0];
    end
  end

  // Sequencing: pushes write one byte per step; pops spend step 0 issuing
  // the first read and commit one byte on each later step.
  assign len     = stack_len(cmd_q);
  assign popping = is_pop(cmd_q);
  always_comb begin
    if (len == 2'd0) begin
      last = 1'b1;
    end else if (popping) begin
      last = (step == len);
    end else begin
      last = (step == len - 2'd1);
    end
  end

  assign done      = ivalid && last && (!ovalid || result.ready);
  assign advance   = ivalid && (!last || done);
  assign accept    = instr.valid && instr.ready;
  assign instr.ready = !ivalid || done;
  assign push_step = advance && (len != 2'd0) && !popping;
  assign pop_step  = advance && popping && (step != 2'd0);

  // bytes pushed: BRK pushes PC+1 high, low, then P with B; JSR pushes PC-1
  assign ret_pc = (cmd_q == CMD_BRK) ? regs.pc + 16'd1 : regs.pc - 16'd1;
  always_comb begin
    case (cmd_q)
      CMD_PHA: push_byte = regs.a;
      CMD_PHP: push_byte = regs.p;
      default: begin
        case (step)
          2'd0:    push_byte = ret_pc[15:8];
          2'd1:    push_byte = ret_pc[7:0];
          default: push_byte = regs.p | FlagB;
        endcase
      end
    endcase
  end

  // the byte committed this step comes straight from the read port
  always_comb begin
    pop_bytes[0] = pop_hold[0];
    pop_bytes[1] = pop_hold[1];
    pop_bytes[2] = rdata;
    if (step == 2'd1) begin
      pop_bytes[0] = rdata;
    end else if (step == 2'd2) begin
      pop_bytes[1] = rdata;
    end
  end

  bcx_alu u_alu (
    .cur          (regs),
    .cmd          (cmd_q),
    .operand      (op_q),
    .operand_high (hi_q),
    .break_vector (break_vector),
    .pop_bytes    (pop_bytes),
    .nxt          (alu_regs),
    .mem_data     (alu_mem),
    .extra_cycles (alu_extra)
  );

  always_comb begin
    regs_next = regs;
    if (done) begin
      regs_next = alu_regs;
    end
    // stack ops move SP one byte per step, overriding the ALU copy
    if (push_step) begin
      regs_next.sp = regs.sp - 8'd1;
    end else if (pop_step) begin
      regs_next.sp = regs.sp + 8'd1;
    end else if (!done) begin
      regs_next.sp = regs.sp;
    end
  end

  // read one above where SP lands, so the next pop finds its byte
  always_comb begin
    stk_req.we    = push_step;
    stk_req.waddr = regs.sp;
    stk_req.wdata = push_byte;
    stk_req.raddr = regs_next.sp + 8'd1;
  end

  bcx_stack u_stack (
    .clk   (clk),
    .rst   (rst),
    .req   (stk_req),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      regs   <= '{a: 8'h00, x: 8'h00, y: 8'h00, sp: SpReset, p: 8'h00, pc: 16'h0000};
      ivalid <= 1'b0;
      step   <= 2'd0;
      ovalid <= 1'b0;
    end else begin
      regs <= regs_next;
      if (accept) begin
        ivalid <= 1'b1;
        step   <= 2'd0;
      end else if (done) begin
        ivalid <= 1'b0;
        step   <= 2'd0;
      end else if (advance) begin
        step <= step + 2'd1;
      end
      if (done) begin
        ovalid <= 1'b1;
      end else if (result.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  // payload registers: hold request fields, pop bytes and result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= instr.cmd;
      op_q  <= instr.operand;
      hi_q  <= instr.operand_high;
    end
    if (pop_step && step == 2'd1) begin
      pop_hold[0] <= rdata;
    end
    if (pop_step && step == 2'd2) begin
      pop_hold[1] <= rdata;
    end
    if (done) begin
      result.mem_data     <= alu_mem;
      result.acc_out      <= regs_next.a;
      result.x_out        <= regs_next.x;
      result.y_out        <= regs_next.y;
      result.sp_out       <= regs_next.sp;
      result.status_out   <= regs_next.p;
      result.pc_out       <= regs_next.pc;
      result.extra_cycles <= alu_extra;
    end
  end

  assign result.valid = ovalid;

  // step never runs past the instruction's stack length
  assert property (@(posedge clk) disable iff (rst) ivalid |-> step <= len)
    else $error("sequencer step beyond stack length");
  // an idle request register sits at step zero
  assert property (@(posedge clk) disable iff (rst) !ivalid |-> step == 2'd0)
    else $error("step nonzero with no request held");
  // a finished instruction always lands in the result register
  assert property (@(posedge clk) disable iff (rst) done |=> ovalid)
    else $error("completed request lost");
  // stack writes and pop commits never overlap
  assert property (@(posedge clk) disable iff (rst) !(push_step && pop_step))
    else $error("push and pop in one cycle");

endmodule

@@ tb/tb_top.sv @@
// Testbench for the byte CPU execute unit: drives requests, predicts every result
// from its own model of the register file and stack page, and compares field by field.
// Depends on bcx_pkg, bcx_if and the RTL.
module tb_top;
  import bcx_pkg::*;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  bcx_in_if  instr();
  bcx_out_if result();

  byte_cpu_execute_unit dut (
    .clk(clk), .rst(rst), .instr(instr), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  typedef struct packed {
    logic [7:0]  mem;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  p;
    logic [15:0] pc;
    logic [1:0]  extra;
  } cpu_view_t;

  // Model state of the CPU
  logic [7:0]  m_a, m_x, m_y, m_sp, m_p;
  logic [15:0] m_pc, m_vector;
  logic [7:0]  m_stack [256];

  cpu_view_t expected_views[$];
  int errors;
  int cycles;
  int gap_pct;   // sender idle percentage
  int stall_pct; // receiver stall percentage

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bound the run; stack instructions and stalls slow it down.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    errors++;
  endtask

  function automatic void set_flag(input logic [7:0] bit_mask, input logic on);
    if (on) m_p = m_p | bit_mask;
    else m_p = m_p & ~bit_mask;
  endfunction

  function automatic void set_nz(input logic [7:0] v);
    set_flag(FlagZ, v == 8'd0);
    set_flag(FlagN, v[7]);
  endfunction

  function automatic void push_byte(input logic [7:0] v);
    m_stack[m_sp] = v;
    m_sp = m_sp - 8'd1;
  endfunction

  function automatic logic [7:0] pop_byte();
    m_sp = m_sp + 8'd1;
    return m_stack[m_sp];
  endfunction

  function automatic logic [1:0] take_branch(input logic cond, input logic [7:0] off);
    logic [15:0] target;
    if (!cond) return ExtraNone;
    target = m_pc + {{8{off[7]}}, off};
    take_branch = (m_pc[15:8] != target[15:8]) ? ExtraPage : ExtraTaken;
    m_pc = target;
  endfunction

  function automatic void compare_reg(input logic [7:0] r, input logic [7:0] v);
    set_flag(FlagC, r >= v);
    set_nz(r - v);
  endfunction

  function automatic void add_acc(input logic [7:0] v);
    logic [31:0] a, c, s;
    a = m_a;
    c = (m_p & FlagC) ? 1 : 0;
    s = a + v + c;
    set_flag(FlagZ, s[7:0] == 0);
    if (m_p & FlagD) begin
      if (a[3:0] + v[3:0] + c > 9) s += 6;
      set_flag(FlagN, s[7]);
      set_flag(FlagV, !((a ^ v) & 32'h80) && ((a ^ s) & 32'h80));
      if (s > 32'h99) s += 96;
      set_flag(FlagC, s > 32'h99);
    end else begin
      set_flag(FlagN, s[7]);
      set_flag(FlagV, !((a ^ v) & 32'h80) && ((a ^ s) & 32'h80));
      set_flag(FlagC, s > 32'hFF);
    end
    m_a = s[7:0];
  endfunction

  function automatic void sub_acc(input logic [7:0] v);
    logic [31:0] a, b, d;
    a = m_a;
    b = (m_p & FlagC) ? 0 : 1;
    d = a - v - b;
    set_flag(FlagN, d[7]);
    set_flag(FlagZ, d[7:0] == 0);
    set_flag(FlagV, ((a ^ d) & 32'h80) && ((a ^ v) & 32'h80));
    if (m_p & FlagD) begin
      if ($signed(a[3:0] - b) < $signed({28'd0, v[3:0]})) d -= 6;
      if (d > 32'h99) d -= 96;
    end
    set_flag(FlagC, d < 32'h100);
    m_a = d[7:0];
  endfunction

  function automatic cpu_view_t execute(input logic [5:0] op, input logic [7:0] v,
                                        input logic [7:0] hi);
    cpu_view_t r;
    logic [7:0] mem, t;
    logic [1:0] extra;
    mem = 8'd0;
    extra = ExtraNone;
    case (op)
      CMD_ADC: add_acc(v);
      CMD_AND: begin m_a &= v; set_nz(m_a); end
      CMD_ASL: begin set_flag(FlagC, v[7]); mem = v << 1; set_nz(mem); end
      CMD_BCC: extra = take_branch(!(m_p & FlagC), v);
      CMD_BCS: extra = take_branch((m_p & FlagC) != 0, v);
      CMD_BEQ: extra = take_branch((m_p & FlagZ) != 0, v);
      CMD_BIT: begin
        set_flag(FlagV, v[6]);
        set_flag(FlagN, v[7]);
        set_flag(FlagZ, (v & m_a) == 0);
      end
      CMD_BMI: extra = take_branch((m_p & FlagN) != 0, v);
      CMD_BNE: extra = take_branch(!(m_p & FlagZ), v);
      CMD_BPL: extra = take_branch(!(m_p & FlagN), v);
      CMD_BRK: begin
        m_pc = m_pc + 16'd1;
        push_byte(m_pc[15:8]);
        push_byte(m_pc[7:0]);
        push_byte(m_p | FlagB);
        set_flag(FlagI, 1'b1);
        m_pc = m_vector;
      end
      CMD_BVC: extra = take_branch(!(m_p & FlagV), v);
      CMD_BVS: extra = take_branch((m_p & FlagV) != 0, v);
      CMD_CLC: set_flag(FlagC, 1'b0);
      CMD_CLD: set_flag(FlagD, 1'b0);
      CMD_CLI: set_flag(FlagI, 1'b0);
      CMD_CLV: set_flag(FlagV, 1'b0);
      CMD_CMP: compare_reg(m_a, v);
      CMD_CPX: compare_reg(m_x, v);
      CMD_CPY: compare_reg(m_y, v);
      CMD_DEC: begin mem = v - 8'd1; set_nz(mem); end
      CMD_DEX: begin m_x = m_x - 8'd1; set_nz(m_x); end
      CMD_DEY: begin m_y = m_y - 8'd1; set_nz(m_y); end
      CMD_EOR: begin m_a ^= v; set_nz(m_a); end
      CMD_INC: begin mem = v + 8'd1; set_nz(mem); end
      CMD_INX: begin m_x = m_x + 8'd1; set_nz(m_x); end
      CMD_INY: begin m_y = m_y + 8'd1; set_nz(m_y); end
      CMD_JMP: m_pc = {hi, v};
      CMD_JSR: begin
        m_pc = m_pc - 16'd1;
        push_byte(m_pc[15:8]);
        push_byte(m_pc[7:0]);
        m_pc = {hi, v};
      end
      CMD_LDA: begin m_a = v; set_nz(m_a); end
      CMD_LDX: begin m_x = v; set_nz(m_x); end
      CMD_LDY: begin m_y = v; set_nz(m_y); end
      CMD_LSR: begin set_flag(FlagC, v[0]); mem = v >> 1; set_nz(mem); end
      CMD_NOP: ;
      CMD_ORA: begin m_a |= v; set_nz(m_a); end
      CMD_PHA: push_byte(m_a);
      CMD_PHP: push_byte(m_p);
      CMD_PLA: begin m_a = pop_byte(); set_nz(m_a); end
      CMD_PLP: m_p = pop_byte();
      CMD_ROL: begin
        t = (m_p & FlagC) ? 8'h01 : 8'h00;
        set_flag(FlagC, v[7]);
        mem = (v << 1) | t;
        set_nz(mem);
      end
      CMD_ROR: begin
        t = (m_p & FlagC) ? 8'h80 : 8'h00;
        set_flag(FlagC, v[0]);
        mem = (v >> 1) | t;
        set_nz(mem);
      end
      CMD_RTI: begin
        m_p = pop_byte();
        t = pop_byte();
        m_pc = {pop_byte(), t};
      end
      CMD_RTS: begin
        t = pop_byte();
        m_pc = {pop_byte(), t};
        m_pc = m_pc + 16'd1;
      end
      CMD_SBC: sub_acc(v);
      CMD_SEC: set_flag(FlagC, 1'b1);
      CMD_SED: set_flag(FlagD, 1'b1);
      CMD_SEI: set_flag(FlagI, 1'b1);
      CMD_STA: mem = m_a;
      CMD_STX: mem = m_x;
      CMD_STY: mem = m_y;
      CMD_TAX: begin m_x = m_a; set_nz(m_x); end
      CMD_TAY: begin m_y = m_a; set_nz(m_y); end
      CMD_TSX: begin m_x = m_sp; set_nz(m_x); end
      CMD_TXA: begin m_a = m_x; set_nz(m_a); end
      CMD_TXS: m_sp = m_x;
      CMD_TYA: begin m_a = m_y; set_nz(m_a); end
      default: ; // unused codes change nothing
    endcase
    r = '{mem: mem, a: m_a, x: m_x, y: m_y, sp: m_sp, p: m_p, pc: m_pc, extra: extra};
    return r;
  endfunction

  // Send one request; idle before it at the current rate and hold until accepted.
  // valid stays up after acceptance; the next idle cycle or drain drops it.
  task automatic send_request(input logic [5:0] op, input logic [7:0] v, input logic [7:0] hi);
    while ($urandom_range(99) < gap_pct) begin
      instr.valid <= 1'b0;
      @(posedge clk);
    end
    instr.valid <= 1'b1;
    instr.cmd <= op;
    instr.operand <= v;
    instr.operand_high <= hi;
    @(posedge clk);
    while (!instr.ready) @(posedge clk);
    expected_views.push_back(execute(op, v, hi));
  endtask

  // Receiver: stall at random, check each accepted result against the oldest prediction.
  initial begin
    cpu_view_t want;
    result.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && result.valid && result.ready) begin
        if (expected_views.size() == 0) begin
          report("unexpected result", 16'd0, 16'd0);
        end else begin
          want = expected_views.pop_front();
          if (result.mem_data !== want.mem)
            report("mem_data", {8'd0, result.mem_data}, {8'd0, want.mem});
          if (result.acc_out !== want.a)
            report("acc_out", {8'd0, result.acc_out}, {8'd0, want.a});
          if (result.x_out !== want.x)
            report("x_out", {8'd0, result.x_out}, {8'd0, want.x});
          if (result.y_out !== want.y)
            report("y_out", {8'd0, result.y_out}, {8'd0, want.y});
          if (result.sp_out !== want.sp)
            report("sp_out", {8'd0, result.sp_out}, {8'd0, want.sp});
          if (result.status_out !== want.p)
            report("status_out", {8'd0, result.status_out}, {8'd0, want.p});
          if (result.pc_out !== want.pc) report("pc_out", result.pc_out, want.pc);
          if (result.extra_cycles !== want.extra)
            report("extra_cycles", {14'd0, result.extra_cycles}, {14'd0, want.extra});
        end
      end
      result.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Drain: drop valid, wait until every predicted result has come, then let the unit settle.
  task automatic drain();
    instr.valid <= 1'b0;
    while (expected_views.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // APB write of break_vector; only while the unit is idle.
  task automatic write_vector(input logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {RegBreakVector, 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    m_vector = value;
  endtask

  // Directed: field extremes, every command, decimal and page-crossing cases.
  task automatic test_directed();
    send_request(CMD_LDA, 8'h00, 8'h00);
    send_request(CMD_LDA, 8'hFF, 8'hFF);
    send_request(CMD_SED, 8'h00, 8'h00);
    send_request(CMD_ADC, 8'h99, 8'h00);  // decimal add overflows past 99
    send_request(CMD_SBC, 8'h01, 8'h00);  // decimal subtract, carry set so no borrow in
    send_request(CMD_CLD, 8'h00, 8'h00);
    send_request(CMD_JMP, 8'hF0, 8'h12);
    send_request(CMD_SEC, 8'h00, 8'h00);
    send_request(CMD_BCS, 8'h7F, 8'h00);  // forward across a page
    send_request(CMD_BCS, 8'h80, 8'h00);  // backward offset
    send_request(CMD_JMP, 8'hFF, 8'hFF);
    send_request(CMD_BRK, 8'h00, 8'h00);  // pc wraps on increment
    send_request(CMD_RTI, 8'h00, 8'h00);
    send_request(CMD_JMP, 8'h00, 8'h00);
    send_request(CMD_JSR, 8'h34, 8'h12);  // pc wraps on decrement
    send_request(CMD_RTS, 8'h00, 8'h00);
    send_request(CMD_LDX, 8'h00, 8'h00);
    send_request(CMD_TXS, 8'h00, 8'h00);
    send_request(CMD_PHP, 8'h00, 8'h00);  // stack pointer wraps below zero
    send_request(CMD_PLA, 8'h00, 8'h00);
    for (int c = 0; c < 64; c++)
      send_request(c[5:0], 8'($urandom_range(255)), 8'($urandom_range(255)));
  endtask

  // Random: random command codes, unused ones included, with random operands.
  task automatic test_random(input int count);
    logic [5:0] op;
    for (int i = 0; i < count; i++) begin
      // Neither idle the sender nor stall the receiver through the middle stretch.
      gap_pct = (i > count / 3 && i < count / 2) ? 0 : 17;
      stall_pct = gap_pct;
      op = 6'($urandom_range(63));
      send_request(op, 8'($urandom_range(255)), 8'($urandom_range(255)));
    end
    gap_pct = 17;
    stall_pct = 17;
  endtask

  initial begin
    logic [15:0] vectors [4];
    errors = 0;
    cycles = 0;
    gap_pct = 17;
    stall_pct = 17;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    instr.valid = 1'b0;
    instr.cmd = CMD_NOP;
    instr.operand = 8'd0;
    instr.operand_high = 8'd0;
    m_a = 0; m_x = 0; m_y = 0; m_sp = SpReset; m_p = 0; m_pc = 0;
    m_vector = BreakVectorReset;
    foreach (m_stack[i]) m_stack[i] = 8'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    drain();  // sender pauses until every result is in
    vectors = '{16'h0000, 16'hFFFF, 16'h8000, 16'h1234};
    foreach (vectors[k]) begin
      write_vector(vectors[k]);
      test_random(190);
      drain();
    end

    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end
endmodule
